/* src/tcec_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcec_pkg: shared types and constants
// Slot count, coordinate width, event codes and the token that walks the
// cell chain.
// ---------------------------------------------------------------------------
package tcec_pkg;

  localparam int MaxContacts = 8;
  localparam int CoordBits   = 16;
  localparam int IdBits      = 32;

  typedef enum logic [1:0] {
    EV_DOWN = 2'd0,
    EV_UP   = 2'd1,
    EV_MOVE = 2'd2,
    EV_SAME = 2'd3
  } event_e;

  // Report in flight through the chain, with its search status.
  typedef struct packed {
    logic [IdBits-1:0]    id;
    logic                 on;
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic                 done;       // hit or stored in an earlier cell
    logic                 any_valid;  // passed at least one filled slot
    event_e               ev;
  } token_t;

endpackage

/* src/tcec_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcec_cell: one contact slot
// Holds one table entry, checks the passing token against it, updates or
// claims the slot and hands the token to the next cell.
// ---------------------------------------------------------------------------
module tcec_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tok_vld_i,
  input  tcec_pkg::token_t tok_i,
  output logic            tok_vld_o,
  output tcec_pkg::token_t tok_o
);

  logic                           slot_vld_q, slot_vld_d;
  logic [tcec_pkg::IdBits-1:0]    slot_id_q;
  logic                           slot_on_q;
  logic [tcec_pkg::CoordBits-1:0] slot_x_q;
  logic [tcec_pkg::CoordBits-1:0] slot_y_q;

  logic             hit, claim;
  tcec_pkg::token_t tok_d;
  logic             tok_vld_q;
  tcec_pkg::token_t tok_q;

  assign hit   = tok_vld_i && !tok_i.done && slot_vld_q && (slot_id_q == tok_i.id);
  assign claim = tok_vld_i && !tok_i.done && !slot_vld_q;
  assign slot_vld_d = slot_vld_q | claim;

  always_comb begin
    tok_d = tok_i;
    if (slot_vld_q) begin
      tok_d.any_valid = 1'b1;
    end
    priority if (hit) begin
      tok_d.done = 1'b1;
      priority if (slot_on_q && tok_i.on) begin
        tok_d.ev = ((slot_x_q == tok_i.x) && (slot_y_q == tok_i.y)) ?
                   tcec_pkg::EV_SAME : tcec_pkg::EV_MOVE;
      end else if (tok_i.on) begin
        tok_d.ev = tcec_pkg::EV_DOWN;
      end else begin
        tok_d.ev = tcec_pkg::EV_UP;
      end
    end else if (claim) begin
      // new contact: up when lifted, else down only on an empty table, else a move
      tok_d.done = 1'b1;
      if (!tok_i.on) begin
        tok_d.ev = tcec_pkg::EV_UP;
      end else if (tok_i.any_valid) begin
        tok_d.ev = tcec_pkg::EV_MOVE;
      end else begin
        tok_d.ev = tcec_pkg::EV_DOWN;
      end
    end else begin
      tok_d.done = tok_i.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= 1'b0;
      tok_vld_q  <= 1'b0;
    end else begin
      slot_vld_q <= slot_vld_d;
      tok_vld_q  <= tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (hit || claim) begin
      slot_id_q <= tok_i.id;
      slot_on_q <= tok_i.on;
      slot_x_q  <= tok_i.x;
      slot_y_q  <= tok_i.y;
    end
  end

  assign tok_vld_o = tok_vld_q;
  assign tok_o     = tok_q;

endmodule

/* src/touch_contact_event_classifier.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// touch_contact_event_classifier: touch report to contact event
// Row of contact slots searched by a token that moves one slot per cycle.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one report (contact_id_i,
//   on_surface_i, pos_x_i, pos_y_i); a transfer happens when valid is high
//   and stall is low. Output channel: out_valid_o / out_stall_i carry one
//   result (event_kind_o, table_full_o) per report.
//   Pipeline: the first slot cell checks the report in its transfer cycle,
//   then the token moves one cell per cycle through each cell's register
//   and lands in the result register, which drives out_valid_o.
//   Flow: one report in flight; the next report is taken in the cycle
//   its predecessor's result transfers, so no new report enters before
//   the last one's result has left.
//   Reset empties every slot and drops any report in flight.
//   While the receiver stalls the result holds and in_stall_o stays high.
//   Slots fill from the lowest index and are never freed; a new contact on
//   a full table is not stored and is flagged by table_full_o.
// ---------------------------------------------------------------------------
module touch_contact_event_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] contact_id_i,
  input  logic        on_surface_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_kind_o,
  output logic        table_full_o
);

  localparam int N = tcec_pkg::MaxContacts;

  logic             [N:0] chain_vld;
  tcec_pkg::token_t       chain_tok [N+1];

  logic            busy_q, busy_d;
  logic            out_valid_q, out_valid_d;
  tcec_pkg::event_e ev_q, ev_d;
  logic            full_q, full_d;
  logic            in_xfer, out_xfer;

  assign out_xfer   = out_valid_q && !out_stall_i;
  // take a new report when idle or when the pending result leaves now
  assign in_stall_o = busy_q && !out_xfer;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // inject the report at the head of the chain
  assign chain_vld[0] = in_xfer;
  assign chain_tok[0] = '{id:        contact_id_i,
                          on:        on_surface_i,
                          x:         pos_x_i[tcec_pkg::CoordBits-1:0],
                          y:         pos_y_i[tcec_pkg::CoordBits-1:0],
                          done:      1'b0,
                          any_valid: 1'b0,
                          ev:        tcec_pkg::EV_UP};

  for (genvar k = 0; k < N; k++) begin : g_cell
    tcec_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_vld_i (chain_vld[k]),
      .tok_i     (chain_tok[k]),
      .tok_vld_o (chain_vld[k+1]),
      .tok_o     (chain_tok[k+1])
    );
  end

  // result capture at the tail; a token that nobody took means a full table
  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    ev_d        = ev_q;
    full_d      = full_q;
    if (out_xfer) begin
      out_valid_d = 1'b0;
      busy_d      = 1'b0;
    end
    if (in_xfer) begin
      busy_d = 1'b1;
    end
    if (chain_vld[N]) begin
      out_valid_d = 1'b1;
      if (chain_tok[N].done) begin
        ev_d   = chain_tok[N].ev;
        full_d = 1'b0;
      end else begin
        ev_d   = chain_tok[N].on ? tcec_pkg::EV_MOVE : tcec_pkg::EV_UP;
        full_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q   <= ev_d;
    full_q <= full_d;
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = ev_q;
  assign table_full_o = full_q;

`ifndef ASSERT_OFF
  a_one_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(chain_vld[N:1]) <= 1)
    else $error("more than one report in the chain");

  a_chain_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|chain_vld[N:1]) |-> (busy_q && in_stall_o))
    else $error("chain active while input not stalled");

  a_result_alone : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(|chain_vld[N:1]))
    else $error("result pending while chain active");

  a_full_event : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && full_q) |-> (ev_q == tcec_pkg::EV_MOVE || ev_q == tcec_pkg::EV_UP))
    else $error("table full with a down or unchanged event");
`endif

endmodule

/* tb/touch_event_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// touch_event_checker: contact event predictor and result check
// Follows every report transfer into a shadow contact table, queues the
// event that report must produce and compares each result transfer with
// the oldest queued event.
// ---------------------------------------------------------------------------
module touch_event_checker
  import tcec_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rpt_valid_i,
  input  logic                 rpt_stall_i,
  input  logic [IdBits-1:0]    rpt_id_i,
  input  logic                 rpt_on_i,
  input  logic [CoordBits-1:0] rpt_x_i,
  input  logic [CoordBits-1:0] rpt_y_i,
  input  logic                 evt_valid_i,
  input  logic                 evt_stall_i,
  input  logic [1:0]           evt_kind_i,
  input  logic                 evt_full_i,
  output int unsigned          mismatches_o,
  output int unsigned          pending_o,
  output int unsigned          checked_o,
  output int unsigned          full_seen_o,
  output int unsigned          same_seen_o
);

  localparam int unsigned MaxPrinted = 20;

  typedef struct {
    event_e kind;
    logic   full;
  } contact_event_t;

  logic                 known_valid [MaxContacts];
  logic [IdBits-1:0]    known_id    [MaxContacts];
  logic                 known_on    [MaxContacts];
  logic [CoordBits-1:0] known_x     [MaxContacts];
  logic [CoordBits-1:0] known_y     [MaxContacts];
  int unsigned          known_count;
  contact_event_t       expected_events [$];
  int unsigned          mismatches;
  int unsigned          checked;
  int unsigned          full_seen;
  int unsigned          same_seen;

  task automatic report_mismatch(input string what);
    if (mismatches < MaxPrinted) begin
      $display("%0t: mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  // Look the id up from the lowest slot, classify, then overwrite or append.
  function automatic contact_event_t classify_report(
    input logic [IdBits-1:0]    id,
    input logic                 on,
    input logic [CoordBits-1:0] x,
    input logic [CoordBits-1:0] y
  );
    contact_event_t ev;
    int             hit;
    hit     = -1;
    ev.full = 1'b0;
    for (int k = 0; k < MaxContacts; k++) begin
      if (hit < 0 && known_valid[k] && known_id[k] == id) begin
        hit = k;
      end
    end
    if (hit >= 0) begin
      if (known_on[hit] && on) begin
        ev.kind = (known_x[hit] == x && known_y[hit] == y) ? EV_SAME : EV_MOVE;
      end else if (on) begin
        ev.kind = EV_DOWN;
      end else begin
        ev.kind = EV_UP;
      end
    end else begin
      // A lifted new contact is an up; otherwise a move once the table holds anything.
      if (!on) begin
        ev.kind = EV_UP;
      end else begin
        ev.kind = (known_count == 0) ? EV_DOWN : EV_MOVE;
      end
      if (known_count < MaxContacts) begin
        hit = known_count;
        known_count++;
      end else begin
        ev.full = 1'b1;
      end
    end
    if (hit >= 0) begin
      known_valid[hit] = 1'b1;
      known_id[hit]    = id;
      known_on[hit]    = on;
      known_x[hit]     = x;
      known_y[hit]     = y;
    end
    return ev;
  endfunction

  task automatic check_event();
    contact_event_t want;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: kind %0d full %0b",
                                evt_kind_i, evt_full_i));
    end else begin
      want = expected_events.pop_front();
      if (evt_kind_i !== want.kind) begin
        report_mismatch($sformatf("event_kind %0d, want %0d", evt_kind_i, want.kind));
      end
      if (evt_full_i !== want.full) begin
        report_mismatch($sformatf("table_full %0b, want %0b", evt_full_i, want.full));
      end
      checked++;
      if (want.full) full_seen++;
      if (want.kind == EV_SAME) same_seen++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxContacts; k++) begin
        known_valid[k] = 1'b0;
      end
      known_count = 0;
      expected_events.delete();
      mismatches = 0;
      checked    = 0;
      full_seen  = 0;
      same_seen  = 0;
    end else begin
      // Pop before push: the result leaving now is always the older one.
      if (evt_valid_i && !evt_stall_i) begin
        check_event();
      end
      if (rpt_valid_i && !rpt_stall_i) begin
        expected_events.push_back(classify_report(rpt_id_i, rpt_on_i, rpt_x_i, rpt_y_i));
      end
    end
    mismatches_o <= mismatches;
    pending_o    <= expected_events.size();
    checked_o    <= checked;
    full_seen_o  <= full_seen;
    same_seen_o  <= same_seen;
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: touch contact event classifier
// Drives touch reports into the classifier with random gaps, stalls the
// result side at random and lets a checker predict and compare every
// contact event. Directed reports cover each classification case; random
// reports then revisit the filled contact table.
// ---------------------------------------------------------------------------
module testbench;
  import tcec_pkg::*;

  localparam int unsigned RandomReports = 1630;
  localparam int unsigned IdleLimit     = 500;   // cycles without any transfer
  localparam int unsigned DrainCycles   = MaxContacts + 4;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [IdBits-1:0]    contact_id_i = '0;
  logic                 on_surface_i = 1'b0;
  logic [CoordBits-1:0] pos_x_i      = '0;
  logic [CoordBits-1:0] pos_y_i      = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [1:0]           event_kind_o;
  logic                 table_full_o;

  int unsigned          mismatches;
  int unsigned          pending;
  int unsigned          checked;
  int unsigned          full_seen;
  int unsigned          same_seen;

  // Ids that end up in the table after the directed part, in slot order.
  logic [IdBits-1:0]    table_ids [MaxContacts];
  logic [CoordBits-1:0] last_x    [MaxContacts];
  logic [CoordBits-1:0] last_y    [MaxContacts];
  logic                 no_idle   = 1'b0;
  int unsigned          reports_sent = 0;
  int unsigned          idle_cycles  = 0;

  touch_contact_event_classifier dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .contact_id_i (contact_id_i),
    .on_surface_i (on_surface_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_kind_o (event_kind_o),
    .table_full_o (table_full_o)
  );

  touch_event_checker event_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rpt_valid_i  (in_valid_i),
    .rpt_stall_i  (in_stall_o),
    .rpt_id_i     (contact_id_i),
    .rpt_on_i     (on_surface_i),
    .rpt_x_i      (pos_x_i),
    .rpt_y_i      (pos_y_i),
    .evt_valid_i  (out_valid_o),
    .evt_stall_i  (out_stall_i),
    .evt_kind_i   (event_kind_o),
    .evt_full_i   (table_full_o),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .full_seen_o  (full_seen),
    .same_seen_o  (same_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Present one report and hold it until the transfer. Valid stays high
  // across back-to-back reports; drop it only when a gap is drawn.
  task automatic send_report(
    input logic [IdBits-1:0]    id,
    input logic                 on,
    input logic [CoordBits-1:0] x,
    input logic [CoordBits-1:0] y
  );
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    contact_id_i <= id;
    on_surface_i <= on;
    pos_x_i      <= x;
    pos_y_i      <= y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    reports_sent++;
  endtask

  // Result side: stall for a drawn number of cycles, then release until
  // one result transfers. The stall does not wait for valid, so it lands
  // on every phase of the slot walk.
  initial begin : result_sink
    int unsigned hold;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 9);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Watchdog: any transfer on either side restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Timeout: no transfer for %0d cycles", IdleLimit);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned          idx;
    int unsigned          pick;
    logic [IdBits-1:0]    id;
    logic                 on;
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;

    // Extreme and alternating bit patterns, so the table ids toggle every bit.
    table_ids[0] = 32'h0000_0000;
    table_ids[1] = 32'hFFFF_FFFF;
    table_ids[2] = 32'h0000_0001;
    table_ids[3] = 32'h8000_0000;
    table_ids[4] = 32'h5A5A_5A5A;
    table_ids[5] = 32'hA5A5_A5A5;
    table_ids[6] = 32'h7FFF_FFFF;
    table_ids[7] = 32'h0001_0000;
    for (int k = 0; k < MaxContacts; k++) begin
      last_x[k] = '0;
      last_y[k] = '0;
    end

    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // First contact on an empty table lands as touch down.
    send_report(table_ids[0], 1'b1, 16'h0000, 16'h0000);
    // Same place again, then moves at the coordinate extremes.
    send_report(table_ids[0], 1'b1, 16'h0000, 16'h0000);
    send_report(table_ids[0], 1'b1, 16'hFFFF, 16'hFFFF);
    send_report(table_ids[0], 1'b1, 16'hFFFF, 16'h0000);   // only y moves
    send_report(table_ids[0], 1'b1, 16'h0000, 16'h0000);   // only x moves
    // Lift, stay lifted, land again.
    send_report(table_ids[0], 1'b0, 16'h1234, 16'h5678);
    send_report(table_ids[0], 1'b0, 16'h1234, 16'h5678);
    send_report(table_ids[0], 1'b1, 16'h1234, 16'h5678);
    // New contacts on a non-empty table: lifted gives up, on gives move.
    send_report(table_ids[1], 1'b0, 16'h8000, 16'h7FFF);
    send_report(table_ids[2], 1'b1, 16'h7FFF, 16'h8000);
    // Fill the remaining slots.
    for (int k = 3; k < MaxContacts; k++) begin
      send_report(table_ids[k], k[0], 16'(100 * k), 16'(200 * k));
    end
    // Table full: unknown ids are flagged and not stored.
    send_report(32'hDEAD_BEEF, 1'b1, 16'hAAAA, 16'h5555);
    send_report(32'h0000_0002, 1'b0, 16'h5555, 16'hAAAA);
    // Hits still work on a full table: land a lifted one, hold another.
    send_report(table_ids[1], 1'b1, 16'h8000, 16'h7FFF);
    send_report(table_ids[7], 1'b1, 16'd700, 16'd1400);
    send_report(table_ids[7], 1'b1, 16'd700, 16'd1400);

    // Mostly hits on the stored contacts, with repeated positions so that
    // unchanged-position moves come up; the rest are unknown ids.
    for (int n = 0; n < RandomReports; n++) begin
      no_idle = (n % 200) >= 160;
      pick    = $urandom_range(0, 99);
      on      = $urandom_range(0, 9) < 7;
      if (pick < 85) begin
        idx = $urandom_range(0, MaxContacts - 1);
        id  = table_ids[idx];
        if ($urandom_range(0, 2) == 0) begin
          x = last_x[idx];
          y = last_y[idx];
        end else begin
          x = CoordBits'($urandom);
          y = CoordBits'($urandom);
        end
        last_x[idx] = x;
        last_y[idx] = y;
      end else begin
        id = $urandom;
        x  = CoordBits'($urandom);
        y  = CoordBits'($urandom);
      end
      send_report(id, on, x, y);
    end
    in_valid_i <= 1'b0;

    // Wait out the last results, then a slot walk and a margin for stray ones.
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d touch reports, checked %0d contact events.", reports_sent, checked);
    $display("Table-full events: %0d, unchanged-position moves: %0d, mismatches: %0d.",
             full_seen, same_seen, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
